### rtl/ostk_pkg.sv
// Shared types and constants for the operand stack.
// Used by ostk_cell, ostk_ctrl and operand_stack_32_64.
`default_nettype none
package ostk_pkg;

  localparam int STACK_WORDS = 256;
  localparam int WORD_W      = 32;
  localparam int VALUE_W     = 2 * WORD_W;
  localparam int CNT_W       = $clog2(STACK_WORDS + 1);
  localparam int HELD_W      = 9;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int OUT_DATA_W  = 80;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH32 = 3'd0,
    REQ_PUSH64 = 3'd1,
    REQ_POP32  = 3'd2,
    REQ_POP64  = 3'd3,
    REQ_PEEK32 = 3'd4,
    REQ_PEEK64 = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SH_HOLD,
    SH_DN1,
    SH_DN2,
    SH_UP1,
    SH_UP2
  } shift_e;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_e            status;
    logic [HELD_W-1:0]  words_held;
  } result_t;

endpackage
`default_nettype wire

### rtl/operand_stack_32_64.sv
// Operand stack of 32-bit words held in a chain of shifting word cells.
// The result item is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the result side takes items; the
// top two cells are read directly, and every cell shifts by one or two words.
// Reset clears the word count and the output valid flag; cell contents and
// the held result stay as they are.
// Depends on ostk_pkg, ostk_cell and ostk_ctrl.
`default_nettype none
module operand_stack_32_64
  import ostk_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [VALUE_W-1:0]    s_axis_tdata,   // [63:0] push_value
  input  wire logic [REQ_W-1:0]      s_axis_tuser,   // [2:0] req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // [63:0] read_value, [72:64] words_held
  output logic      [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  logic              fire;
  shift_e            op;
  result_t           res;
  result_t           res_q;
  logic              vld_q;
  logic [WORD_W-1:0] word [STACK_WORDS];
  logic [WORD_W-1:0] push_lo;
  logic [WORD_W-1:0] push_hi;

  assign push_lo       = s_axis_tdata[WORD_W-1:0];
  assign push_hi       = s_axis_tdata[VALUE_W-1:WORD_W];
  assign s_axis_tready = !vld_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < STACK_WORDS; i++) begin : g_cell
    logic [WORD_W-1:0] dn1;
    logic [WORD_W-1:0] dn2;
    logic [WORD_W-1:0] up1;
    logic [WORD_W-1:0] up2;

    if (i == 0) begin : g_dn_top
      assign dn1 = push_lo;
      assign dn2 = push_lo;
    end else if (i == 1) begin : g_dn_second
      assign dn1 = word[0];
      assign dn2 = push_hi;
    end else begin : g_dn_rest
      assign dn1 = word[i-1];
      assign dn2 = word[i-2];
    end

    if (i + 1 < STACK_WORDS) begin : g_up1
      assign up1 = word[i+1];
    end else begin : g_up1_end
      assign up1 = '0;
    end

    if (i + 2 < STACK_WORDS) begin : g_up2
      assign up2 = word[i+2];
    end else begin : g_up2_end
      assign up2 = '0;
    end

    ostk_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .dn1_i  (dn1),
      .dn2_i  (dn2),
      .up1_i  (up1),
      .up2_i  (up2),
      .word_o (word[i])
    );
  end

  ostk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_type_i (s_axis_tuser),
    .top0_i     (word[0]),
    .top1_i     (word[1]),
    .op_o       (op),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - HELD_W){1'b0}},
                          res_q.words_held, res_q.read_value};
  assign m_axis_tuser  = res_q.status;

endmodule
`default_nettype wire

### rtl/ostk_cell.sv
// One word cell of the stack chain; takes a neighbor's word, or the pushed word at the top, on a shift.
// Depends on ostk_pkg.
`default_nettype none
module ostk_cell
  import ostk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire shift_e            op_i,
  input  wire logic [WORD_W-1:0] dn1_i,
  input  wire logic [WORD_W-1:0] dn2_i,
  input  wire logic [WORD_W-1:0] up1_i,
  input  wire logic [WORD_W-1:0] up2_i,
  output logic      [WORD_W-1:0] word_o
);

  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] word_d;

  always_comb begin
    case (op_i)
      SH_DN1:  word_d = dn1_i;
      SH_DN2:  word_d = dn2_i;
      SH_UP1:  word_d = up1_i;
      SH_UP2:  word_d = up2_i;
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule
`default_nettype wire

### rtl/ostk_ctrl.sv
// Request decode, word count and result formation for the operand stack.
// Depends on ostk_pkg.
`default_nettype none
module ostk_ctrl
  import ostk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [WORD_W-1:0] top0_i,
  input  wire logic [WORD_W-1:0] top1_i,
  output shift_e                 op_o,
  output result_t                res_o
);

  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        cnt_d;
  logic [CNT_W-1:0]        cnt_nx;
  shift_e                  op_nx;
  logic [VALUE_W-1:0]      rv;
  status_e                 st;
  logic [CNT_W+HELD_W-1:0] held_ext;

  localparam logic [CNT_W-1:0] FULL1 = CNT_W'(STACK_WORDS - 1);
  localparam logic [CNT_W-1:0] FULL2 = CNT_W'(STACK_WORDS - 2);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO   = CNT_W'(2);

  always_comb begin
    op_nx  = SH_HOLD;
    cnt_nx = cnt_q;
    rv     = '0;
    st     = ST_OK;
    case (req_e'(req_type_i))
      REQ_PUSH32: begin
        if (cnt_q > FULL1) begin
          st = ST_OVER;
        end else begin
          op_nx  = SH_DN1;
          cnt_nx = cnt_q + ONE;
        end
      end
      REQ_PUSH64: begin
        if (cnt_q > FULL2) begin
          st = ST_OVER;
        end else begin
          op_nx  = SH_DN2;
          cnt_nx = cnt_q + TWO;
        end
      end
      REQ_POP32, REQ_PEEK32: begin
        if (cnt_q < ONE) begin
          st = ST_UNDER;
        end else begin
          rv = {{WORD_W{top0_i[WORD_W-1]}}, top0_i};
          if (req_e'(req_type_i) == REQ_POP32) begin
            op_nx  = SH_UP1;
            cnt_nx = cnt_q - ONE;
          end
        end
      end
      REQ_POP64, REQ_PEEK64: begin
        if (cnt_q < TWO) begin
          st = ST_UNDER;
        end else begin
          rv = {top1_i, top0_i};
          if (req_e'(req_type_i) == REQ_POP64) begin
            op_nx  = SH_UP2;
            cnt_nx = cnt_q - TWO;
          end
        end
      end
      default: begin
        op_nx = SH_HOLD;
      end
    endcase
  end

  assign op_o  = fire_i ? op_nx : SH_HOLD;
  assign cnt_d = fire_i ? cnt_nx : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign held_ext = {{HELD_W{1'b0}}, cnt_nx};

  assign res_o.read_value = rv;
  assign res_o.status     = st;
  assign res_o.words_held = held_ext[HELD_W-1:0];

endmodule
`default_nettype wire
